/* rtl/rbsi_pkg.sv */
package rbsi_pkg;

   localparam int FIELD_W   = 32;
   localparam int FRAC_BITS = 16;
   localparam int SIZE_W    = 31;
   localparam int HALF_W    = 30;
   localparam int TOL_W     = 16;
   localparam int QUOT_W    = 48;

   localparam logic [1:0] NORM_ZERO = 2'b00;
   localparam logic [1:0] NORM_POS  = 2'b01;
   localparam logic [1:0] NORM_NEG  = 2'b11;

   typedef enum logic [1:0] {
      CSR_SIZE_X   = 2'd0,
      CSR_SIZE_Y   = 2'd1,
      CSR_SIZE_Z   = 2'd2,
      CSR_FACE_TOL = 2'd3
   } csr_index_type;

   // ray data riding along the slab dividers
   typedef struct packed {
      logic [2:0][FIELD_W-1:0] org;
      logic [2:0][FIELD_W-1:0] dir;
      logic [FIELD_W-1:0]      t_near;
      logic [FIELD_W-1:0]      t_far;
      logic [5:0]              neg;
      logic [2:0]              zero_dir;
      logic [2:0]              outside;
   } slab_side_type;

   // hit data riding along the face ratio dividers
   typedef struct packed {
      logic [2:0][FIELD_W-1:0] point;
      logic [FIELD_W-1:0]      distance;
      logic                    hit;
   } point_side_type;

endpackage

/* rtl/rbsi_div.sv */
module rbsi_div #(
   parameter int NUM_W  = 48,
   parameter int DEN_W  = 32,
   parameter int LANES  = 6,
   parameter int SIDE_W = 8
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              enable,
   input  logic                              in_valid,
   input  logic [LANES-1:0][NUM_W-1:0]       in_num,
   input  logic [LANES-1:0][DEN_W-1:0]       in_den,
   input  logic [SIDE_W-1:0]                 in_side,
   output logic                              out_valid,
   output logic [LANES-1:0][NUM_W-1:0]       out_quot,
   output logic [SIDE_W-1:0]                 out_side
);

   // restoring division, one quotient bit per stage
   logic [NUM_W-1:0]                        valid_ff;
   logic [NUM_W-1:0][SIDE_W-1:0]            side_ff;
   logic [NUM_W-1:0][LANES-1:0][NUM_W-1:0]  nq_ff, nq_in;
   logic [NUM_W-1:0][LANES-1:0][DEN_W-1:0]  rem_ff, rem_in;
   logic [NUM_W-1:0][LANES-1:0][DEN_W-1:0]  den_ff;

   logic [NUM_W-1:0]                        st_valid;
   logic [NUM_W-1:0][SIDE_W-1:0]            st_side;
   logic [NUM_W-1:0][LANES-1:0][NUM_W-1:0]  st_nq;
   logic [NUM_W-1:0][LANES-1:0][DEN_W-1:0]  st_rem;
   logic [NUM_W-1:0][LANES-1:0][DEN_W-1:0]  st_den;

   for (genvar s = 0; s < NUM_W; s++) begin : g_stage
      if (s == 0) begin : g_first
         assign st_valid[s] = in_valid;
         assign st_side[s]  = in_side;
         assign st_nq[s]    = in_num;
         assign st_den[s]   = in_den;
         assign st_rem[s]   = '0;
      end else begin : g_next
         assign st_valid[s] = valid_ff[s-1];
         assign st_side[s]  = side_ff[s-1];
         assign st_nq[s]    = nq_ff[s-1];
         assign st_den[s]   = den_ff[s-1];
         assign st_rem[s]   = rem_ff[s-1];
      end
   end

   always_comb begin
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           qbit;
      trial = '0;
      diff  = '0;
      qbit  = 1'b0;
      for (int s = 0; s < NUM_W; s++) begin
         for (int l = 0; l < LANES; l++) begin
            trial        = {st_rem[s][l], st_nq[s][l][NUM_W-1]};
            diff         = trial - {1'b0, st_den[s][l]};
            qbit         = (trial >= {1'b0, st_den[s][l]});
            rem_in[s][l] = qbit ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            nq_in[s][l]  = {st_nq[s][l][NUM_W-2:0], qbit};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (enable) begin
         valid_ff <= st_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         side_ff <= st_side;
         nq_ff   <= nq_in;
         rem_ff  <= rem_in;
         den_ff  <= st_den;
      end
   end

   assign out_valid = valid_ff[NUM_W-1];
   assign out_quot  = nq_ff[NUM_W-1];
   assign out_side  = side_ff[NUM_W-1];

endmodule

/* rtl/ray_box_slab_intersect.sv */
// Ray against an origin-centered axis-aligned box, slab method, signed Q16.16.
// One ray word enters per cycle and one result word leaves per cycle. A word
// passes 106 register stages: two 48-stage bit-per-stage dividers (slab
// distances, then face ratios), nine arithmetic stages and the output register.
// All stages advance together; a stalled rsp side holds the whole pipe, and
// req_tready drops only while a result sits unaccepted at the output. Box sizes
// and face tolerance are written on the csr channel; the user must write them
// only while idle, as the block does not enforce it. A missed ray returns
// hit = 0 and zeros in every other field.
module ray_box_slab_intersect
   import rbsi_pkg::*;
#(
   parameter int WORD_BITS = 32
) (
   input  logic         clock,
   input  logic         reset,
   // origin_x, origin_y, origin_z, dir_x, dir_y, dir_z, t_near, t_far
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [255:0] req_tdata,
   // distance, point_x, point_y, point_z, normal_x, normal_y, normal_z, pad
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [135:0] rsp_tdata,
   // hit
   output logic [0:0]   rsp_tuser,
   // config write channel
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [1:0]   csr_index,
   input  logic [31:0]  csr_data
);

   // saturation range of the working word
   localparam int EFF_BITS = (WORD_BITS < 32) ? WORD_BITS : 32;
   localparam logic signed [31:0] SAT_MAX = 32'((64'sd1 <<< (EFF_BITS - 1)) - 64'sd1);
   localparam logic signed [31:0] SAT_MIN = -SAT_MAX - 32'sd1;
   localparam logic [QUOT_W-1:0]  QLIM_POS = QUOT_W'(SAT_MAX);
   localparam logic [QUOT_W-1:0]  QLIM_NEG = QUOT_W'(SAT_MAX) + QUOT_W'(1);
   localparam logic signed [48:0] SAT_MAX_W = 49'(SAT_MAX);
   localparam logic signed [48:0] SAT_MIN_W = 49'(SAT_MIN);

   function automatic logic [31:0] sat_quot(input logic neg, input logic [QUOT_W-1:0] q);
      logic [QUOT_W-1:0] nq;
      nq = ~q + QUOT_W'(1);
      if (neg) begin
         return (q > QLIM_NEG) ? SAT_MIN : nq[31:0];
      end
      return (q > QLIM_POS) ? SAT_MAX : q[31:0];
   endfunction

   function automatic logic [31:0] sat_word(input logic signed [48:0] v);
      if (v > SAT_MAX_W) return SAT_MAX;
      if (v < SAT_MIN_W) return SAT_MIN;
      return v[31:0];
   endfunction

   // ---------------------------------------------------------------- config
   logic [2:0][SIZE_W-1:0] size_ff;
   logic [TOL_W-1:0]       tol_ff;
   logic [2:0][HALF_W-1:0] half;

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= {3{SIZE_W'(65536)}};
         tol_ff  <= TOL_W'(7);
      end else if (csr_valid) begin
         unique case (csr_index_type'(csr_index))
            CSR_SIZE_X:   size_ff[0] <= csr_data[SIZE_W-1:0];
            CSR_SIZE_Y:   size_ff[1] <= csr_data[SIZE_W-1:0];
            CSR_SIZE_Z:   size_ff[2] <= csr_data[SIZE_W-1:0];
            CSR_FACE_TOL: tol_ff     <= csr_data[TOL_W-1:0];
         endcase
      end
   end

   assign csr_ready = 1'b1;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         half[i] = size_ff[i][SIZE_W-1:1];
      end
   end

   // whole pipe moves unless the output word is stuck
   logic en;
   logic rsp_valid_ff;
   assign en         = !rsp_valid_ff || rsp_tready;
   assign req_tready = en;

   // ------------------------------------------ stage 1: slab numerators
   logic                     s1_valid_ff;
   logic [5:0][QUOT_W-1:0]   s1_num_ff, s1_num_in;
   logic [5:0][31:0]         s1_den_ff, s1_den_in;
   slab_side_type            s1_side_ff, s1_side_in;

   always_comb begin
      logic signed [32:0] org_e, dir_e, half_e, na, nb, ma, mb, md;
      logic               zero;
      org_e = '0; dir_e = '0; half_e = '0; na = '0; nb = '0;
      ma = '0; mb = '0; md = '0; zero = 1'b0;
      s1_num_in  = '0;
      s1_den_in  = '0;
      s1_side_in = '0;
      for (int i = 0; i < 3; i++) begin
         half_e = $signed({3'b000, half[i]});
         org_e  = $signed({req_tdata[32*i+31], req_tdata[32*i +: 32]});
         dir_e  = $signed({req_tdata[96+32*i+31], req_tdata[96+32*i +: 32]});
         // distances to the -half and +half planes, before the divide
         na     = -half_e - org_e;
         nb     = half_e - org_e;
         ma     = na[32] ? -na : na;
         mb     = nb[32] ? -nb : nb;
         md     = dir_e[32] ? -dir_e : dir_e;
         zero   = (dir_e == 33'sd0);
         s1_num_in[2*i]   = {ma[31:0], FRAC_BITS'(0)};
         s1_num_in[2*i+1] = {mb[31:0], FRAC_BITS'(0)};
         s1_den_in[2*i]   = zero ? 32'd1 : md[31:0];
         s1_den_in[2*i+1] = zero ? 32'd1 : md[31:0];
         s1_side_in.neg[2*i]   = na[32] ^ dir_e[32];
         s1_side_in.neg[2*i+1] = nb[32] ^ dir_e[32];
         s1_side_in.zero_dir[i] = zero;
         // parallel ray that starts outside the slab never enters it
         s1_side_in.outside[i]  = zero && ((org_e < -half_e) || (org_e > half_e));
         s1_side_in.org[i] = req_tdata[32*i +: 32];
         s1_side_in.dir[i] = req_tdata[96+32*i +: 32];
      end
      s1_side_in.t_near = req_tdata[192 +: 32];
      s1_side_in.t_far  = req_tdata[224 +: 32];
   end

   // ------------------------------------------ slab dividers
   logic                         d1_valid;
   logic [5:0][QUOT_W-1:0]       d1_quot;
   logic [$bits(slab_side_type)-1:0] d1_side_raw;
   slab_side_type                d1_side;

   rbsi_div #(
      .NUM_W  (QUOT_W),
      .DEN_W  (32),
      .LANES  (6),
      .SIDE_W ($bits(slab_side_type))
   ) u_slab_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (en),
      .in_valid (s1_valid_ff),
      .in_num   (s1_num_ff),
      .in_den   (s1_den_ff),
      .in_side  (s1_side_ff),
      .out_valid(d1_valid),
      .out_quot (d1_quot),
      .out_side (d1_side_raw)
   );

   assign d1_side = slab_side_type'(d1_side_raw);

   // ------------------------------------------ stage 2: sign and saturate
   logic             s2_valid_ff;
   logic [5:0][31:0] s2_val_ff, s2_val_in;
   slab_side_type    s2_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (d1_side.zero_dir[i]) begin
            // unbounded slab
            s2_val_in[2*i]   = SAT_MIN;
            s2_val_in[2*i+1] = SAT_MAX;
         end else begin
            s2_val_in[2*i]   = sat_quot(d1_side.neg[2*i], d1_quot[2*i]);
            s2_val_in[2*i+1] = sat_quot(d1_side.neg[2*i+1], d1_quot[2*i+1]);
         end
      end
   end

   // ------------------------------------------ stage 3: order entry / exit
   logic             s3_valid_ff;
   logic [2:0][31:0] s3_lo_ff, s3_lo_in, s3_hi_ff, s3_hi_in;
   slab_side_type    s3_side_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if ($signed(s2_val_ff[2*i]) > $signed(s2_val_ff[2*i+1])) begin
            s3_lo_in[i] = s2_val_ff[2*i+1];
            s3_hi_in[i] = s2_val_ff[2*i];
         end else begin
            s3_lo_in[i] = s2_val_ff[2*i];
            s3_hi_in[i] = s2_val_ff[2*i+1];
         end
      end
   end

   // ------------------------------------------ stage 4: overlap the slabs
   logic          s4_valid_ff;
   logic [31:0]   s4_lo_ff, s4_lo_in, s4_hi_ff, s4_hi_in;
   logic          s4_miss_ff;
   slab_side_type s4_side_ff;

   always_comb begin
      s4_lo_in = s3_lo_ff[0];
      s4_hi_in = s3_hi_ff[0];
      for (int i = 1; i < 3; i++) begin
         if ($signed(s3_lo_ff[i]) > $signed(s4_lo_in)) s4_lo_in = s3_lo_ff[i];
         if ($signed(s3_hi_ff[i]) < $signed(s4_hi_in)) s4_hi_in = s3_hi_ff[i];
      end
   end

   // ------------------------------------------ stage 5: clip to ray interval
   logic          s5_valid_ff;
   logic [31:0]   s5_t_ff, s5_t_in;
   logic          s5_hit_ff, s5_hit_in;
   slab_side_type s5_side_ff;

   always_comb begin
      logic signed [31:0] lo, hi, tn, tf, t;
      lo = $signed(s4_lo_ff);
      hi = $signed(s4_hi_ff);
      tn = $signed(s4_side_ff.t_near);
      tf = $signed(s4_side_ff.t_far);
      // entry distance if past t_near, else exit distance
      t  = (lo > tn) ? lo : hi;
      s5_t_in   = t;
      s5_hit_in = !s4_miss_ff && !(lo > hi) && !(hi < tn) && !(lo > tf)
                  && !(t < tn) && !(t > tf);
   end

   // ------------------------------------------ stage 6: dir * distance
   logic                    s6_valid_ff;
   logic [2:0][63:0]        s6_prod_ff, s6_prod_in;
   logic [2:0][31:0]        s6_org_ff;
   logic [31:0]             s6_t_ff;
   logic                    s6_hit_ff;

   always_comb begin
      logic signed [63:0] p;
      p = '0;
      for (int i = 0; i < 3; i++) begin
         p = $signed(s5_side_ff.dir[i]) * $signed(s5_t_ff);
         s6_prod_in[i] = p;
      end
   end

   // ------------------------------------------ stage 7: hit point
   logic             s7_valid_ff;
   logic [2:0][31:0] s7_pt_ff, s7_pt_in;
   logic [31:0]      s7_t_ff;
   logic             s7_hit_ff;

   always_comb begin
      logic signed [63:0] sh;
      logic signed [48:0] sum;
      sh  = '0;
      sum = '0;
      for (int i = 0; i < 3; i++) begin
         // arithmetic shift rounds toward minus infinity
         sh  = $signed(s6_prod_ff[i]) >>> FRAC_BITS;
         sum = $signed({{17{s6_org_ff[i][31]}}, s6_org_ff[i]}) + $signed(sh[48:0]);
         s7_pt_in[i] = sat_word(sum);
      end
   end

   // ------------------------------------------ stage 8: ratio operands
   logic                   s8_valid_ff;
   logic [2:0][QUOT_W-1:0] s8_num_ff, s8_num_in;
   logic [2:0][HALF_W-1:0] s8_den_ff, s8_den_in;
   point_side_type         s8_side_ff, s8_side_in;

   always_comb begin
      logic signed [32:0] pe, pa;
      pe = '0;
      pa = '0;
      for (int i = 0; i < 3; i++) begin
         pe = $signed({s7_pt_ff[i][31], s7_pt_ff[i]});
         pa = pe[32] ? -pe : pe;
         s8_num_in[i] = {pa[31:0], FRAC_BITS'(0)};
         // zero half-size counts as one lsb
         s8_den_in[i] = (half[i] == '0) ? HALF_W'(1) : half[i];
      end
      s8_side_in.point    = s7_pt_ff;
      s8_side_in.distance = s7_t_ff;
      s8_side_in.hit      = s7_hit_ff;
   end

   // ------------------------------------------ face ratio dividers
   logic                              d2_valid;
   logic [2:0][QUOT_W-1:0]            d2_quot;
   logic [$bits(point_side_type)-1:0] d2_side_raw;

   rbsi_div #(
      .NUM_W  (QUOT_W),
      .DEN_W  (HALF_W),
      .LANES  (3),
      .SIDE_W ($bits(point_side_type))
   ) u_ratio_div (
      .clock    (clock),
      .reset    (reset),
      .enable   (en),
      .in_valid (s8_valid_ff),
      .in_num   (s8_num_ff),
      .in_den   (s8_den_ff),
      .in_side  (s8_side_ff),
      .out_valid(d2_valid),
      .out_quot (d2_quot),
      .out_side (d2_side_raw)
   );

   // ------------------------------------------ stage 9: largest ratio
   logic                   s9_valid_ff;
   logic [QUOT_W-1:0]      s9_max_ff, s9_max_in;
   logic [2:0][QUOT_W-1:0] s9_ratio_ff;
   point_side_type         s9_side_ff;

   always_comb begin
      s9_max_in = d2_quot[0];
      if (d2_quot[1] > s9_max_in) s9_max_in = d2_quot[1];
      if (d2_quot[2] > s9_max_in) s9_max_in = d2_quot[2];
   end

   // ------------------------------------------ stage 10: face and output word
   logic [135:0] rsp_data_ff, rsp_data_in;
   logic         rsp_hit_ff;

   always_comb begin
      logic [QUOT_W-1:0]  tol_e;
      logic [2:0][1:0]    nrm;
      logic [1:0]         axis;
      tol_e = QUOT_W'(tol_ff);
      nrm   = {3{NORM_ZERO}};
      // ties favor x, then y, then z
      priority if (s9_max_ff - s9_ratio_ff[0] < tol_e) begin
         axis = 2'd0;
      end else if (s9_max_ff - s9_ratio_ff[1] < tol_e) begin
         axis = 2'd1;
      end else begin
         axis = 2'd2;
      end
      nrm[axis] = ($signed(s9_side_ff.point[axis]) > 32'sd0) ? NORM_POS : NORM_NEG;
      if (s9_side_ff.hit) begin
         rsp_data_in = {2'b00, nrm[2], nrm[1], nrm[0], s9_side_ff.point[2],
                        s9_side_ff.point[1], s9_side_ff.point[0], s9_side_ff.distance};
      end else begin
         rsp_data_in = '0;
      end
   end

   // ------------------------------------------ pipeline registers
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff  <= req_tvalid;
         s2_valid_ff  <= d1_valid;
         s3_valid_ff  <= s2_valid_ff;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= d2_valid;
         rsp_valid_ff <= s9_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_num_ff   <= s1_num_in;
         s1_den_ff   <= s1_den_in;
         s1_side_ff  <= s1_side_in;
         s2_val_ff   <= s2_val_in;
         s2_side_ff  <= d1_side;
         s3_lo_ff    <= s3_lo_in;
         s3_hi_ff    <= s3_hi_in;
         s3_side_ff  <= s2_side_ff;
         s4_lo_ff    <= s4_lo_in;
         s4_hi_ff    <= s4_hi_in;
         s4_miss_ff  <= |s3_side_ff.outside;
         s4_side_ff  <= s3_side_ff;
         s5_t_ff     <= s5_t_in;
         s5_hit_ff   <= s5_hit_in;
         s5_side_ff  <= s4_side_ff;
         s6_prod_ff  <= s6_prod_in;
         s6_org_ff   <= s5_side_ff.org;
         s6_t_ff     <= s5_t_ff;
         s6_hit_ff   <= s5_hit_ff;
         s7_pt_ff    <= s7_pt_in;
         s7_t_ff     <= s6_t_ff;
         s7_hit_ff   <= s6_hit_ff;
         s8_num_ff   <= s8_num_in;
         s8_den_ff   <= s8_den_in;
         s8_side_ff  <= s8_side_in;
         s9_max_ff   <= s9_max_in;
         s9_ratio_ff <= d2_quot;
         s9_side_ff  <= point_side_type'(d2_side_raw);
         rsp_data_ff <= rsp_data_in;
         rsp_hit_ff  <= s9_side_ff.hit;
      end
   end

   assign rsp_tvalid   = rsp_valid_ff;
   assign rsp_tdata    = rsp_data_ff;
   assign rsp_tuser[0] = rsp_hit_ff;

   // ------------------------------------------ checks
   // a miss carries an all-zero word
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] |-> rsp_tdata == '0)
      else $error("miss word not cleared");

   // a hit names exactly one face
   a_one_face: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |->
         $countones({|rsp_tdata[129:128], |rsp_tdata[131:130], |rsp_tdata[133:132]}) == 1)
      else $error("hit without a single face normal");

   // input backpressure only comes from a stuck output word
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("pipe stalled without output backpressure");

endmodule
